// File: src/sc2a_pkg.sv
// ----------------------------------------------------------------------------
// sc2a_pkg
// Shared types, key codes and set-1 lookup tables for the scan code
// translator.
// ----------------------------------------------------------------------------
package sc2a_pkg;

	localparam int unsigned CODE_W = 8;
	localparam int unsigned CHAR_W = 7;
	localparam int unsigned MAP_AW = 6;

	localparam logic [CODE_W-1:0] CODE_CAPS        = 8'd58;
	localparam logic [CODE_W-1:0] CODE_LSHIFT_MAKE = 8'd42;
	localparam logic [CODE_W-1:0] CODE_LSHIFT_BRK  = 8'd170;

	localparam logic [CHAR_W-1:0] CASE_OFFSET = 7'h20;
	localparam logic [CHAR_W-1:0] LOWER_LO    = 7'h60;
	localparam logic [CHAR_W-1:0] LOWER_HI    = 7'h7b;
	localparam logic [CHAR_W-1:0] UPPER_LO    = 7'h40;
	localparam logic [CHAR_W-1:0] UPPER_HI    = 7'h5b;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [CHAR_W-1:0] char_t;

	typedef struct packed {
		logic shift_held;
		logic caps_on;
		logic caps_parity;
	} flags_t;

	typedef struct packed {
		logic   emit;
		char_t  ch;
		flags_t flags_nxt;
	} xlate_t;

	localparam char_t PLAIN_MAP [0:63] = '{
		7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0d, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
		7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h00,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	localparam char_t SHIFTED_MAP [0:63] = '{
		7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e,
		7'h26, 7'h2a, 7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0d, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
		7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h00,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

endpackage

// File: src/sc2a_xlate.sv
// ----------------------------------------------------------------------------
// sc2a_xlate
// Single-pass decode of one scan code: modifier handling, table lookup and
// caps lock case inversion. Purely combinational.
// ----------------------------------------------------------------------------
module sc2a_xlate (
	input  sc2a_pkg::code_t  code,
	input  sc2a_pkg::flags_t flags,
	output sc2a_pkg::xlate_t res
);
	import sc2a_pkg::*;

	char_t map_ch;
	char_t base_ch;

	assign map_ch  = flags.shift_held ? SHIFTED_MAP[code[MAP_AW-1:0]]
	                                  : PLAIN_MAP[code[MAP_AW-1:0]];
	assign base_ch = code[MAP_AW] ? '0 : map_ch;

	always_comb begin
		res.emit      = 1'b0;
		res.ch        = base_ch;
		res.flags_nxt = flags;
		if (code == CODE_CAPS) begin
			res.flags_nxt.caps_parity = ~flags.caps_parity;
			if (flags.caps_parity) begin
				res.flags_nxt.caps_on = ~flags.caps_on;
			end
		end else if (code == CODE_LSHIFT_MAKE) begin
			res.flags_nxt.shift_held = 1'b1;
		end else if (code == CODE_LSHIFT_BRK) begin
			res.flags_nxt.shift_held = 1'b0;
		end else if (!code[CODE_W-1]) begin
			res.emit = 1'b1;
			if (flags.caps_on) begin
				if (!flags.shift_held && base_ch > LOWER_LO && base_ch < LOWER_HI) begin
					res.ch = base_ch - CASE_OFFSET;
				end else if (flags.shift_held && base_ch > UPPER_LO
				             && base_ch < UPPER_HI) begin
					res.ch = base_ch + CASE_OFFSET;
				end
			end
		end
	end

endmodule

// File: src/sc2a_out_buf.sv
// ----------------------------------------------------------------------------
// sc2a_out_buf
// Two-entry output register with skid slot; ready toward the core is
// registered.
// ----------------------------------------------------------------------------
module sc2a_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sc2a_pkg::char_t push_ch,
	output logic            space,
	output logic            out_valid,
	input  logic            out_ready,
	output sc2a_pkg::char_t ascii_char
);
	import sc2a_pkg::*;

	logic  out_valid_q;
	logic  skid_valid_q;
	char_t out_ch_q;
	char_t skid_ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_ch_q <= skid_valid_q ? skid_ch_q : push_ch;
		end else if (push) begin
			skid_ch_q <= push_ch;
		end
	end

	assign space      = ~skid_valid_q;
	assign out_valid  = out_valid_q;
	assign ascii_char = out_ch_q;

endmodule

// File: src/scancode_to_ascii_translator_top.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_translator_top
// Set-1 scan code to ASCII translator with shift and caps lock tracking.
// ----------------------------------------------------------------------------
// One scan code is taken per clock cycle unless a character is held back by a
// full output register. A code passes an input register, is decoded by one
// stage of table lookup and case logic and lands in a two-entry output
// register, and input keeps flowing while one result waits downstream.
// Modifier and caps lock codes update the flags; they and all other break
// codes produce no output; unmapped make codes give 0.
// ----------------------------------------------------------------------------
module scancode_to_ascii_translator_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sc2a_pkg::code_t scan_code,
	output logic            out_valid,
	input  logic            out_ready,
	output sc2a_pkg::char_t ascii_char
);
	import sc2a_pkg::*;

	logic   valid_s1;
	code_t  code_s1;
	flags_t flags_q;
	xlate_t res;
	logic   space;
	logic   advance;

	sc2a_xlate u_xlate (
		.code  (code_s1),
		.flags (flags_q),
		.res   (res)
	);

	assign advance  = valid_s1 && (!res.emit || space);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flags_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				flags_q <= res.flags_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			code_s1 <= scan_code;
		end
	end

	sc2a_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (advance && res.emit),
		.push_ch    (res.ch),
		.space      (space),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ascii_char (ascii_char)
	);

endmodule

// File: src/sc2a_checker.sv
// ----------------------------------------------------------------------------
// sc2a_checker
// Port-level checks for the scan code translator, bound to the top level.
// ----------------------------------------------------------------------------
module sc2a_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input sc2a_pkg::code_t scan_code,
	input logic            out_valid,
	input logic            out_ready,
	input sc2a_pkg::char_t ascii_char
);
	import sc2a_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ascii_char))
		else $error("result changed while stalled");

	// a result needs an earlier input transfer
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without input transfer");

	// empty output side never stalls input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// only the mapped control characters appear
	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ascii_char == 7'h00 || ascii_char == 7'h08 ||
		               ascii_char == 7'h09 || ascii_char == 7'h0d ||
		               ascii_char == 7'h1b || ascii_char >= 7'h20))
		else $error("unexpected control character");

endmodule

bind scancode_to_ascii_translator_top sc2a_checker u_sc2a_checker (.*);

// File: test/tb_scancode_to_ascii_translator_top.sv
// ----------------------------------------------------------------------------
// tb_scancode_to_ascii_translator_top
// Self-checking bench for the set-1 scan code to ASCII translator.
// ----------------------------------------------------------------------------
// A queue-fed driver offers scan codes and a monitor predicts each character
// from its own copy of the shift and caps lock flags, then checks every output
// transfer in order. A directed pass covers the table edges, modifiers, caps
// lock parity and ignored codes. Random passes follow, with random idling on
// both sides, a stretch without idling, drains between phases and one long
// receiver hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_scancode_to_ascii_translator_top;

	import sc2a_pkg::*;

	localparam int unsigned MAKE_MAX       = 127;
	localparam int unsigned MAP_DEPTH      = 64;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned HOLD_AFTER     = 150;
	localparam int unsigned DRAIN_CYCLES   = 20;

	localparam code_t DIRECTED [0:24] = '{
		8'd0, 8'd255, 8'd127, 8'd128, 8'd30,
		CODE_CAPS, CODE_CAPS, 8'd30, 8'd44, CODE_LSHIFT_MAKE,
		8'd30, 8'd2, 8'd54, 8'd26, CODE_LSHIFT_BRK,
		8'd16, 8'd64, 8'd200, 8'd57, CODE_CAPS,
		8'd41, CODE_CAPS, 8'd63, 8'd18, CODE_LSHIFT_BRK
	};

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  in_valid  = 1'b0;
	logic  in_ready;
	code_t scan_code = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	char_t ascii_char;

	logic in_hs  = 1'b0;
	logic out_hs = 1'b0;

	code_t  pending_codes [$];
	char_t  expected_chars [$];
	flags_t kbd_flags = '0;

	int unsigned idle_pct      = 32;
	int unsigned codes_sent    = 0;
	int unsigned chars_checked = 0;
	int unsigned silent_codes  = 0;
	int unsigned mismatches    = 0;
	int unsigned hold_left     = 0;
	bit          hold_done     = 1'b0;
	int unsigned quiet_cycles  = 0;

	scancode_to_ascii_translator_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.scan_code  (scan_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ascii_char (ascii_char)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// updates kbd_flags; returns 1 when the code yields a character
	function automatic bit kbd_translate(input code_t code, output char_t ch);
		char_t c;
		c  = '0;
		ch = '0;
		if (code == CODE_CAPS) begin
			if (kbd_flags.caps_parity) begin
				kbd_flags.caps_on     = ~kbd_flags.caps_on;
				kbd_flags.caps_parity = 1'b0;
			end else begin
				kbd_flags.caps_parity = 1'b1;
			end
			return 1'b0;
		end
		if (code == CODE_LSHIFT_MAKE) begin
			kbd_flags.shift_held = 1'b1;
			return 1'b0;
		end
		if (code == CODE_LSHIFT_BRK) begin
			kbd_flags.shift_held = 1'b0;
			return 1'b0;
		end
		if (code > MAKE_MAX)
			return 1'b0;
		if (code < MAP_DEPTH)
			c = kbd_flags.shift_held ? SHIFTED_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
		if (kbd_flags.caps_on) begin
			if (!kbd_flags.shift_held && c > LOWER_LO && c < LOWER_HI)
				c = c - CASE_OFFSET;
			else if (kbd_flags.shift_held && c > UPPER_LO && c < UPPER_HI)
				c = c + CASE_OFFSET;
		end
		ch = c;
		return 1'b1;
	endfunction

	// mostly typing with modifiers, plus unmapped, break and raw noise codes
	function automatic code_t rand_code();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45)
			return code_t'($urandom_range(63));
		else if (pick < 55)
			return code_t'($urandom_range(127, 64));
		else if (pick < 63)
			return CODE_LSHIFT_MAKE;
		else if (pick < 71)
			return CODE_LSHIFT_BRK;
		else if (pick < 79)
			return CODE_CAPS;
		else if (pick < 87)
			return code_t'($urandom_range(255, 128));
		else
			return code_t'($urandom_range(255));
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_hs) begin
				if (pending_codes.size() != 0 && $urandom_range(99) >= idle_pct) begin
					in_valid  <= 1'b1;
					scan_code <= pending_codes.pop_front();
				end else begin
					in_valid  <= 1'b0;
					scan_code <= code_t'($urandom_range(255));
				end
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && chars_checked >= HOLD_AFTER) begin
			out_ready <= 1'b0;
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else begin
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		char_t exp_ch;
		char_t pred_ch;
		in_hs  <= arst_n && in_valid && in_ready;
		out_hs <= arst_n && out_valid && out_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					$display("%0t unexpected character: expected none, actual %h",
						$time, ascii_char);
					mismatches++;
				end else begin
					exp_ch = expected_chars.pop_front();
					if (ascii_char !== exp_ch) begin
						$display("%0t ascii_char mismatch: expected %h, actual %h",
							$time, exp_ch, ascii_char);
						mismatches++;
					end
					chars_checked++;
				end
			end
			if (in_valid && in_ready) begin
				codes_sent++;
				if (kbd_translate(scan_code, pred_ch))
					expected_chars.push_back(pred_ch);
				else
					silent_codes++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no transfer for %0d cycles, %0d characters outstanding",
					$time, quiet_cycles, expected_chars.size());
				$display("FAIL scancode_to_ascii_translator_top");
				$finish;
			end
		end
	end

	task automatic drain();
		while (pending_codes.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			pending_codes.push_back(DIRECTED[i]);
		drain();

		idle_pct = 32;
		repeat (400)
			pending_codes.push_back(rand_code());
		drain();

		idle_pct = 0;
		repeat (200)
			pending_codes.push_back(rand_code());
		drain();

		idle_pct = 32;
		repeat (200)
			pending_codes.push_back(rand_code());
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_chars.size() != 0) begin
			$display("%0t %0d expected characters never arrived",
				$time, expected_chars.size());
			mismatches++;
		end

		$display("Covered %0d scan code transfers (%0d silent modifier, caps or break codes)",
			codes_sent, silent_codes);
		$display("Checked %0d characters, %0d mismatches", chars_checked, mismatches);
		if (mismatches == 0)
			$display("PASS scancode_to_ascii_translator_top");
		else
			$display("FAIL scancode_to_ascii_translator_top");
		$finish;
	end

endmodule
